### sv/dtf_pkg.sv
// Shared types, constants and tables for the decimal text to fixed point block.
package dtf_pkg;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] FRAC_CAP = 5'd18;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] CFG_SCALE       = 2'd0;
  localparam logic [1:0] CFG_FRAC_DIGITS = 2'd1;
  localparam logic [1:0] CFG_ALLOW_MINUS = 2'd2;
  localparam logic [1:0] CFG_UPPER_LIMIT = 2'd3;

  localparam logic [62:0] SCALE_RST       = 63'd10000;
  localparam logic [4:0]  FRAC_DIGITS_RST = 5'd4;
  localparam logic        ALLOW_MINUS_RST = 1'b0;
  localparam logic [62:0] UPPER_LIMIT_RST = {63{1'b1}};

  typedef enum logic [2:0] {
    TK_NONE,
    TK_DIGIT,
    TK_MINUS,
    TK_PLUS,
    TK_POINT,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  digit;
    logic        last;
  } tok_t;

  // finished parse of one string, handed to the scaling pipeline
  typedef struct packed {
    logic [63:0] whole;
    logic [59:0] frac;
    logic        good;
    logic        neg;
  } rec_t;

  function automatic logic [59:0] pow10(input logic [4:0] k);
    logic [59:0] r;
    case (k)
      5'd0:    r = 60'd1;
      5'd1:    r = 60'd10;
      5'd2:    r = 60'd100;
      5'd3:    r = 60'd1000;
      5'd4:    r = 60'd10000;
      5'd5:    r = 60'd100000;
      5'd6:    r = 60'd1000000;
      5'd7:    r = 60'd10000000;
      5'd8:    r = 60'd100000000;
      5'd9:    r = 60'd1000000000;
      5'd10:   r = 60'd10000000000;
      5'd11:   r = 60'd100000000000;
      5'd12:   r = 60'd1000000000000;
      5'd13:   r = 60'd10000000000000;
      5'd14:   r = 60'd100000000000000;
      5'd15:   r = 60'd1000000000000000;
      5'd16:   r = 60'd10000000000000000;
      5'd17:   r = 60'd100000000000000000;
      5'd18:   r = 60'd1000000000000000000;
      default: r = 60'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/dtf_front.sv
// Front end: takes character requests and classifies each byte into a token.
module dtf_front (
  input  logic              char_valid,
  input  logic [7:0]        character,
  input  logic              has_char,
  input  logic              last,
  input  logic              q_full,
  output logic              char_stall,
  output logic              push,
  output dtf_pkg::tok_t     tok
);

  logic [7:0] dval;

  assign dval       = character - dtf_pkg::CH_ZERO;
  assign char_stall = q_full;
  // an empty non-final request changes nothing, so it is dropped here
  assign push       = char_valid && !q_full && (has_char || last);

  always_comb begin
    tok.digit = dval[3:0];
    tok.last  = last;
    if (!has_char) begin
      tok.kind = dtf_pkg::TK_NONE;
    end else if (character >= dtf_pkg::CH_ZERO && character <= dtf_pkg::CH_NINE) begin
      tok.kind = dtf_pkg::TK_DIGIT;
    end else if (character == dtf_pkg::CH_MINUS) begin
      tok.kind = dtf_pkg::TK_MINUS;
    end else if (character == dtf_pkg::CH_PLUS) begin
      tok.kind = dtf_pkg::TK_PLUS;
    end else if (character == dtf_pkg::CH_POINT) begin
      tok.kind = dtf_pkg::TK_POINT;
    end else begin
      tok.kind = dtf_pkg::TK_OTHER;
    end
  end

endmodule

### sv/dtf_queue.sv
// Token queue between the front end and the parser.
module dtf_queue #(
  parameter int DEPTH = dtf_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dtf_pkg::tok_t wr_tok,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output dtf_pkg::tok_t rd_tok
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dtf_pkg::tok_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_tok    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count above depth");

endmodule

### sv/dtf_parse.sv
// Parser: consumes tokens, accumulates integer and padded fraction digits.
module dtf_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  input  dtf_pkg::tok_t tok,
  input  logic          advance,
  input  logic [4:0]    frac_digits,
  input  logic          allow_minus,
  output logic          pop,
  output logic          rec_valid,
  output dtf_pkg::rec_t rec
);

  typedef enum logic [1:0] {
    PH_START,
    PH_INT,
    PH_FRAC
  } phase_t;

  phase_t      phase, phase_next, upd_phase;
  logic [63:0] whole, whole_next, upd_whole;
  logic        ovf, ovf_next, upd_ovf;
  logic [59:0] frac, frac_next, upd_frac;
  logic [4:0]  fcnt, fcnt_next, upd_fcnt;
  logic        int_seen, int_seen_next, upd_int_seen;
  logic        neg, neg_next, upd_neg;
  logic        failed, failed_next, upd_failed;

  logic [4:0]  eff;
  logic [4:0]  pidx;
  logic [59:0] p10;
  logic [59:0] term;
  logic [67:0] wide;

  assign pop       = tok_valid && advance;
  assign rec_valid = pop && tok.last;

  assign eff  = (frac_digits > dtf_pkg::FRAC_CAP) ? dtf_pkg::FRAC_CAP : frac_digits;
  assign pidx = eff - fcnt - 5'd1;
  assign p10  = dtf_pkg::pow10(pidx);
  // new digit lands at its final padded place
  assign term = ({60{tok.digit[0]}} & p10)
              + ({60{tok.digit[1]}} & (p10 << 1))
              + ({60{tok.digit[2]}} & (p10 << 2))
              + ({60{tok.digit[3]}} & (p10 << 3));
  assign wide = {whole, 3'b000} + {3'b000, whole, 1'b0} + {64'd0, tok.digit};

  always_comb begin
    phase_t ph;
    logic   handled;
    ph           = phase;
    handled      = 1'b0;
    upd_phase    = phase;
    upd_whole    = whole;
    upd_ovf      = ovf;
    upd_frac     = frac;
    upd_fcnt     = fcnt;
    upd_int_seen = int_seen;
    upd_neg      = neg;
    upd_failed   = failed;
    if (pop && tok.kind != dtf_pkg::TK_NONE) begin
      if (phase == PH_START) begin
        ph        = PH_INT;
        upd_phase = PH_INT;
        if (tok.kind == dtf_pkg::TK_MINUS) begin
          handled = 1'b1;
          upd_neg = 1'b1;
          if (!allow_minus) begin
            upd_failed = 1'b1;
          end
        end else if (tok.kind == dtf_pkg::TK_PLUS) begin
          handled = 1'b1;
        end
      end
      if (!handled) begin
        case (ph)
          PH_INT: begin
            if (tok.kind == dtf_pkg::TK_POINT) begin
              if (!int_seen) begin
                upd_failed = 1'b1;
              end
              upd_phase = PH_FRAC;
            end else if (tok.kind == dtf_pkg::TK_DIGIT) begin
              upd_int_seen = 1'b1;
              if (wide[67:64] != 4'd0) begin
                upd_ovf = 1'b1;
              end else begin
                upd_whole = wide[63:0];
              end
            end else begin
              upd_failed = 1'b1;
            end
          end
          PH_FRAC: begin
            if (tok.kind != dtf_pkg::TK_DIGIT) begin
              upd_failed = 1'b1;
            end else if (fcnt >= eff) begin
              upd_failed = 1'b1;
            end else begin
              upd_frac = frac + term;
              upd_fcnt = fcnt + 5'd1;
            end
          end
          default: begin
            upd_failed = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    rec.whole = upd_whole;
    rec.frac  = upd_frac;
    rec.good  = !upd_failed && !upd_ovf && upd_int_seen;
    rec.neg   = upd_neg;
    if (rec_valid) begin
      phase_next    = PH_START;
      whole_next    = '0;
      ovf_next      = 1'b0;
      frac_next     = '0;
      fcnt_next     = '0;
      int_seen_next = 1'b0;
      neg_next      = 1'b0;
      failed_next   = 1'b0;
    end else begin
      phase_next    = upd_phase;
      whole_next    = upd_whole;
      ovf_next      = upd_ovf;
      frac_next     = upd_frac;
      fcnt_next     = upd_fcnt;
      int_seen_next = upd_int_seen;
      neg_next      = upd_neg;
      failed_next   = upd_failed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      whole    <= '0;
      ovf      <= 1'b0;
      frac     <= '0;
      fcnt     <= '0;
      int_seen <= 1'b0;
      neg      <= 1'b0;
      failed   <= 1'b0;
    end else begin
      phase    <= phase_next;
      whole    <= whole_next;
      ovf      <= ovf_next;
      frac     <= frac_next;
      fcnt     <= fcnt_next;
      int_seen <= int_seen_next;
      neg      <= neg_next;
      failed   <= failed_next;
    end
  end

  a_fcnt_cap: assert property (@(posedge clk) disable iff (rst) fcnt <= dtf_pkg::FRAC_CAP)
    else $error("fraction digit count above cap");

endmodule

### sv/dtf_finish.sv
// Scaling pipeline: whole*scale+fraction with range checks, and the result register.
module dtf_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  input  dtf_pkg::rec_t      rec,
  input  logic [62:0]        scale,
  input  logic [62:0]        upper_limit,
  output logic               ready,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               ok,
  output logic signed [63:0] result_value
);

  logic          en;
  logic          v1, v2, v3, v4, v5;
  dtf_pkg::rec_t r1, r2, r3, r4, r5;
  logic [63:0]   s1_m0, s2_m0, s3_m0;
  logic [62:0]   s2_m1, s3_m1;
  logic [63:0]   s3_m2;
  logic          s3_big;
  logic [62:0]   s4_p;
  logic          s4_pok;
  logic [63:0]   s5_mag;
  logic          s5_ok;
  logic [65:0]   t;
  logic [63:0]   mag;

  assign en    = !(result_valid && result_stall);
  assign ready = en;

  assign t   = 66'(s3_m1) + 66'(s3_m2) + 66'(s3_m0[63:32]);
  assign mag = {1'b0, s4_p} + {4'd0, r4.frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1           <= rec_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      v5           <= v4;
      result_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1     <= rec;
      s1_m0  <= 64'(rec.whole[31:0]) * 64'(scale[31:0]);
      r2     <= r1;
      s2_m0  <= s1_m0;
      s2_m1  <= 63'(r1.whole[31:0]) * 63'(scale[62:32]);
      r3     <= r2;
      s3_m0  <= s2_m0;
      s3_m1  <= s2_m1;
      s3_m2  <= 64'(r2.whole[63:32]) * 64'(scale[31:0]);
      s3_big <= (r2.whole[63:32] != 32'd0) && (scale[62:32] != 31'd0);
      r4     <= r3;
      s4_p   <= {t[30:0], s3_m0[31:0]};
      s4_pok <= !s3_big && (t[65:31] == 35'd0);
      r5     <= r4;
      s5_mag <= mag;
      s5_ok  <= r4.good && s4_pok && (scale != 63'd0) && !mag[63]
                && (mag[62:0] <= upper_limit);
      ok     <= s5_ok;
      if (!s5_ok) begin
        result_value <= '0;
      end else if (r5.neg) begin
        result_value <= $signed(64'd0 - s5_mag);
      end else begin
        result_value <= $signed(s5_mag);
      end
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
                                result_valid && !ok |-> result_value == 64'sd0)
    else $error("failed result carries a nonzero value");
  a_hold: assert property (@(posedge clk) disable iff (rst)
                           result_valid && result_stall |=> result_valid && $stable(result_value))
    else $error("stalled result changed");

endmodule

### sv/decimal_text_to_fixed_point.sv
// Top level: ASCII decimal text to scaled signed 64-bit fixed point.
// Throughput: one character request per cycle while the queue is not full; the queue absorbs short result stalls.
// whole*scale is computed as a three-stage 32x32 partial-product multiply.
// Reset clears the queue, the parse state and the pipeline valids, and loads
// configuration defaults; there is no clearing pass.
module decimal_text_to_fixed_point #(
  parameter int QUEUE_DEPTH = dtf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         character,
  input  logic               has_char,
  input  logic               last,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               ok,
  output logic signed [63:0] result_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [62:0]        cfg_data
);

  logic [62:0] scale;
  logic [4:0]  frac_digits;
  logic        allow_minus;
  logic [62:0] upper_limit;

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_not_empty;
  dtf_pkg::tok_t f_tok;
  dtf_pkg::tok_t q_tok;
  logic          p_rec_valid;
  dtf_pkg::rec_t p_rec;
  logic          fin_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale       <= dtf_pkg::SCALE_RST;
      frac_digits <= dtf_pkg::FRAC_DIGITS_RST;
      allow_minus <= dtf_pkg::ALLOW_MINUS_RST;
      upper_limit <= dtf_pkg::UPPER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtf_pkg::CFG_SCALE:       scale       <= cfg_data;
        dtf_pkg::CFG_FRAC_DIGITS: frac_digits <= cfg_data[4:0];
        dtf_pkg::CFG_ALLOW_MINUS: allow_minus <= cfg_data[0];
        dtf_pkg::CFG_UPPER_LIMIT: upper_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dtf_front u_front (
    .char_valid (char_valid),
    .character  (character),
    .has_char   (has_char),
    .last       (last),
    .q_full     (q_full),
    .char_stall (char_stall),
    .push       (q_push),
    .tok        (f_tok)
  );

  dtf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_tok    (f_tok),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_tok    (q_tok)
  );

  dtf_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .tok_valid   (q_not_empty),
    .tok         (q_tok),
    .advance     (fin_ready),
    .frac_digits (frac_digits),
    .allow_minus (allow_minus),
    .pop         (q_pop),
    .rec_valid   (p_rec_valid),
    .rec         (p_rec)
  );

  dtf_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .rec_valid    (p_rec_valid),
    .rec          (p_rec),
    .scale        (scale),
    .upper_limit  (upper_limit),
    .ready        (fin_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ok           (ok),
    .result_value (result_value)
  );

endmodule
